[src/mptr_pkg.sv]
// ----------------------------------------------------------------------------
// mptr_pkg: shared constants and types of the trigger responder
// Table sizes, derived widths, item kinds and the structures passed between
// the matching engine, the output stage and the top level.
// ----------------------------------------------------------------------------
package mptr_pkg;

  localparam int MAX_TRIGGERS = 8;
  localparam int MAX_PATTERN  = 32;
  localparam int MAX_REPLIES  = 8;

  localparam int TRIG_W = $clog2(MAX_TRIGGERS);      // trigger index
  localparam int CNT_W  = $clog2(MAX_TRIGGERS + 1);  // trigger count
  localparam int PAT_IW = $clog2(MAX_PATTERN);       // byte index in a pattern
  localparam int PAT_LW = $clog2(MAX_PATTERN + 1);   // pattern length
  localparam int REP_IW = $clog2(MAX_REPLIES);       // response slot
  localparam int REP_CW = $clog2(MAX_REPLIES + 1);   // response count
  localparam int PAT_AW = TRIG_W + PAT_IW;
  localparam int REP_AW = TRIG_W + REP_IW;
  localparam int PAT_DEPTH = MAX_TRIGGERS * MAX_PATTERN;
  localparam int REP_DEPTH = MAX_TRIGGERS * MAX_REPLIES;
  localparam int REP_DW    = 32;

  localparam logic [1:0] KIND_BEGIN   = 2'd0;
  localparam logic [1:0] KIND_PATTERN = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_DATA    = 2'd3;

  typedef struct packed {
    logic [TRIG_W-1:0] trig;
    logic [REP_IW-1:0] slot;
    logic [15:0]       tag;
    logic [15:0]       len;
  } res_t;

  typedef struct packed {
    logic vld;
    logic last;
    res_t res;
  } res_push_t;

  typedef struct packed {
    logic idle;
    logic pend_v;
  } eng_status_t;

endpackage

[src/multi_pattern_trigger_responder.sv]
// ----------------------------------------------------------------------------
// multi_pattern_trigger_responder: KMP trigger table with round-robin replies
// Matches a received byte stream against up to eight loaded patterns and
// emits the current response of every trigger that completes a match.
// ----------------------------------------------------------------------------
// Usage. Every input transaction carries a kind. A begin opens a new trigger
// with its pattern length and response capacity; pattern bytes follow one
// per transaction and each one extends the KMP failure table as it arrives;
// add-response transactions append a tag and length to the newest trigger.
// A data byte walks all triggers in load order and produces one result
// transaction for each trigger whose pattern completes and that holds a
// response, the final one of the byte flagged by out_last. A data byte
// that completes nothing gives no result at all.
// Begin, add-response and a pattern's first byte are handled in the idle
// state. Later pattern bytes read and compare, with a failure table read
// and a new compare per failure step, then write their entry. A data byte
// does the same for each complete trigger and reads the response of each
// match that has one, through the single pattern memory port feeding one
// byte compare. Reset clears the trigger table; memories keep their contents
// but are only read where written. The output register lets the block finish
// an item while the receiver stalls; the walk waits only when a result is
// ready while the output register still holds one the receiver has not taken.
// ----------------------------------------------------------------------------
module multi_pattern_trigger_responder import mptr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte_value,
  input  logic [5:0]  in_pattern_length,
  input  logic [3:0]  in_response_capacity,
  input  logic [15:0] in_response_tag,
  input  logic [15:0] in_response_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_trigger_index,
  output logic [2:0]  out_response_slot,
  output logic [15:0] out_reply_tag,
  output logic [15:0] out_reply_length,
  output logic        out_last
);

  res_push_t   push;
  eng_status_t status;
  logic        out_free;

  // The engine holds back each result until it knows whether another one
  // follows, so that the last flag is right on the final transaction.
  mptr_engine u_engine (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_byte_value        (in_byte_value),
    .in_pattern_length    (in_pattern_length),
    .in_response_capacity (in_response_capacity),
    .in_response_tag      (in_response_tag),
    .in_response_length   (in_response_length),
    .out_free             (out_free),
    .push                 (push),
    .status               (status)
  );

  mptr_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .free              (out_free),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_trigger_index (out_trigger_index),
    .out_response_slot (out_response_slot),
    .out_reply_tag     (out_reply_tag),
    .out_reply_length  (out_reply_length),
    .out_last          (out_last)
  );

  // A result is never held over once the engine is idle again.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    status.idle |-> !status.pend_v)
    else $error("result still pending while idle");

  // The engine only writes the output register when it is free.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> out_free)
    else $error("result pushed over an untaken one");

  // The final result of a data byte ends the walk.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld && push.last |=> status.idle)
    else $error("walk continued after the last result");

endmodule

[src/mptr_ram.sv]
// ----------------------------------------------------------------------------
// mptr_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mptr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/mptr_out.sv]
// ----------------------------------------------------------------------------
// mptr_out: result output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module mptr_out import mptr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  res_push_t   push,
  output logic        free,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_trigger_index,
  output logic [2:0]  out_response_slot,
  output logic [15:0] out_reply_tag,
  output logic [15:0] out_reply_length,
  output logic        out_last
);

  logic valid_r, valid_nxt;
  res_t res_r;
  logic last_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push.vld) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (push.vld) begin
      res_r  <= push.res;
      last_r <= push.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_trigger_index = 3'(res_r.trig);
  assign out_response_slot = 3'(res_r.slot);
  assign out_reply_tag     = res_r.tag;
  assign out_reply_length  = res_r.len;
  assign out_last          = last_r;

endmodule

[src/mptr_engine.sv]
// ----------------------------------------------------------------------------
// mptr_engine: trigger table and KMP sequencer
// One byte comparator, stepped by a small sequencer, serves both the failure
// table build and the match walk over all triggers.
// ----------------------------------------------------------------------------
module mptr_engine import mptr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte_value,
  input  logic [5:0]  in_pattern_length,
  input  logic [3:0]  in_response_capacity,
  input  logic [15:0] in_response_tag,
  input  logic [15:0] in_response_length,
  input  logic        out_free,
  output res_push_t   push,
  output eng_status_t status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDP  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_RRD  = 3'd5;
  localparam logic [2:0] S_SEL  = 3'd6;
  localparam logic [2:0] S_END  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PAT_LW-1:0] bl_r, bl_nxt;
  logic [PAT_IW-1:0] prefix_r, prefix_nxt;
  logic [CNT_W-1:0]  t_r, t_nxt;
  logic [PAT_LW-1:0] k_r, k_nxt;
  logic [7:0]        b_r, b_nxt;
  logic              mode_r, mode_nxt;   // high while building a failure table
  res_t              pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;

  logic [PAT_LW-1:0] psize_r [MAX_TRIGGERS];
  logic [PAT_IW-1:0] mpos_r  [MAX_TRIGGERS];
  logic [REP_IW-1:0] rot_r   [MAX_TRIGGERS];
  logic [REP_CW-1:0] cap_r   [MAX_TRIGGERS];
  logic [REP_CW-1:0] scnt_r  [MAX_TRIGGERS];

  logic              begin_we, reply_add, pos_we, rot_we;
  logic [PAT_IW-1:0] pos_wdata;
  logic [REP_IW-1:0] rot_wdata;

  logic              pat_we, pat_re, fail_we, fail_re, rep_we, rep_re;
  logic [PAT_AW-1:0] pat_waddr, pat_raddr, fail_waddr, fail_raddr;
  logic [PAT_IW-1:0] fail_wdata;
  logic [7:0]        pat_rdata;
  logic [PAT_IW-1:0] fail_rdata;
  logic [REP_DW-1:0] rep_rdata;

  logic [TRIG_W-1:0] tix, cix, nix;
  logic [CNT_W-1:0]  newest;
  logic              complete, byte_eq;
  logic [PAT_LW-1:0] sat_len;
  logic [REP_CW-1:0] sat_cap;

  assign tix    = t_r[TRIG_W-1:0];
  assign cix    = count_r[TRIG_W-1:0];
  assign newest = count_r - 1'b1;
  assign nix    = newest[TRIG_W-1:0];

  assign sat_len = (in_pattern_length > MAX_PATTERN) ? PAT_LW'(MAX_PATTERN)
                                                     : PAT_LW'(in_pattern_length);
  assign sat_cap = (in_response_capacity > MAX_REPLIES) ? REP_CW'(MAX_REPLIES)
                                                        : REP_CW'(in_response_capacity);

  // The newest trigger only takes part once all its pattern bytes are in.
  assign complete = (psize_r[tix] != '0) &&
                    ((t_r + 1'b1 != count_r) || (bl_r >= psize_r[tix]));
  assign byte_eq  = (pat_rdata == b_r);

  assign pat_waddr  = {nix, bl_r[PAT_IW-1:0]};
  assign fail_raddr = {tix, k_r[PAT_IW-1:0] - 1'b1};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    bl_nxt     = bl_r;
    prefix_nxt = prefix_r;
    t_nxt      = t_r;
    k_nxt      = k_r;
    b_nxt      = b_r;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    begin_we   = 1'b0;
    reply_add  = 1'b0;
    pos_we     = 1'b0;
    pos_wdata  = '0;
    rot_we     = 1'b0;
    rot_wdata  = '0;
    pat_we     = 1'b0;
    pat_re     = 1'b0;
    pat_raddr  = {tix, k_r[PAT_IW-1:0]};
    fail_we    = 1'b0;
    fail_waddr = {tix, bl_r[PAT_IW-1:0]};
    fail_wdata = '0;
    fail_re    = 1'b0;
    rep_we     = 1'b0;
    rep_re     = 1'b0;
    push       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_BEGIN: begin
              if (count_r < MAX_TRIGGERS) begin
                begin_we   = 1'b1;
                count_nxt  = count_r + 1'b1;
                bl_nxt     = '0;
                prefix_nxt = '0;
              end
            end
            KIND_PATTERN: begin
              if (count_r != '0 && bl_r < psize_r[nix]) begin
                pat_we   = 1'b1;
                b_nxt    = in_byte_value;
                t_nxt    = newest;
                mode_nxt = 1'b1;
                if (bl_r == '0) begin
                  fail_we    = 1'b1;
                  fail_waddr = {nix, bl_r[PAT_IW-1:0]};
                  bl_nxt     = PAT_LW'(1);
                  prefix_nxt = '0;
                end else begin
                  k_nxt     = PAT_LW'(prefix_r);
                  state_nxt = S_RDP;
                end
              end
            end
            KIND_REPLY: begin
              if (count_r != '0 && scnt_r[nix] < cap_r[nix]) begin
                rep_we    = 1'b1;
                reply_add = 1'b1;
              end
            end
            KIND_DATA: begin
              b_nxt     = in_byte_value;
              t_nxt     = '0;
              mode_nxt  = 1'b0;
              state_nxt = S_SEL;
            end
            default: ;
          endcase
        end
      end
      S_SEL: begin
        if (t_r >= count_r) begin
          state_nxt = S_END;
        end else if (!complete) begin
          t_nxt = t_r + 1'b1;
        end else begin
          k_nxt     = PAT_LW'(mpos_r[tix]);
          state_nxt = S_RDP;
        end
      end
      S_RDP: begin
        pat_re    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!byte_eq && k_r != '0) begin
          fail_re   = 1'b1;
          state_nxt = S_FRD;
        end else begin
          k_nxt     = k_r + PAT_LW'(byte_eq);
          state_nxt = S_FIN;
        end
      end
      S_FRD: begin
        k_nxt     = PAT_LW'(fail_rdata);
        pat_re    = 1'b1;
        pat_raddr = {tix, fail_rdata};
        state_nxt = S_CMP;
      end
      S_FIN: begin
        if (mode_r) begin
          fail_we    = 1'b1;
          fail_wdata = k_r[PAT_IW-1:0];
          prefix_nxt = k_r[PAT_IW-1:0];
          bl_nxt     = bl_r + 1'b1;
          state_nxt  = S_IDLE;
        end else if (k_r >= psize_r[tix]) begin
          pos_we = 1'b1;
          if (scnt_r[tix] != '0) begin
            rep_re    = 1'b1;
            state_nxt = S_RRD;
          end else begin
            t_nxt     = t_r + 1'b1;
            state_nxt = S_SEL;
          end
        end else begin
          pos_we    = 1'b1;
          pos_wdata = k_r[PAT_IW-1:0];
          t_nxt     = t_r + 1'b1;
          state_nxt = S_SEL;
        end
      end
      S_RRD: begin
        // A held result goes out only once we know another follows it.
        if (!pend_v_r || out_free) begin
          push.vld   = pend_v_r;
          push.last  = 1'b0;
          push.res   = pend_r;
          pend_nxt   = '{trig: tix, slot: rot_r[tix],
                         tag: rep_rdata[31:16], len: rep_rdata[15:0]};
          pend_v_nxt = 1'b1;
          rot_we     = 1'b1;
          rot_wdata  = (REP_CW'(rot_r[tix]) + 1'b1 == scnt_r[tix]) ? '0
                                                                   : rot_r[tix] + 1'b1;
          t_nxt      = t_r + 1'b1;
          state_nxt  = S_SEL;
        end
      end
      S_END: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push.vld   = 1'b1;
          push.last  = 1'b1;
          push.res   = pend_r;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      bl_r     <= '0;
      prefix_r <= '0;
      t_r      <= '0;
      k_r      <= '0;
      mode_r   <= 1'b0;
      pend_v_r <= 1'b0;
      for (int i = 0; i < MAX_TRIGGERS; i++) begin
        psize_r[i] <= '0;
        mpos_r[i]  <= '0;
        rot_r[i]   <= '0;
        cap_r[i]   <= '0;
        scnt_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      bl_r     <= bl_nxt;
      prefix_r <= prefix_nxt;
      t_r      <= t_nxt;
      k_r      <= k_nxt;
      mode_r   <= mode_nxt;
      pend_v_r <= pend_v_nxt;
      if (begin_we) begin
        psize_r[cix] <= sat_len;
        cap_r[cix]   <= sat_cap;
        scnt_r[cix]  <= '0;
        mpos_r[cix]  <= '0;
        rot_r[cix]   <= '0;
      end
      if (reply_add) begin
        scnt_r[nix] <= scnt_r[nix] + 1'b1;
      end
      if (pos_we) begin
        mpos_r[tix] <= pos_wdata;
      end
      if (rot_we) begin
        rot_r[tix] <= rot_wdata;
      end
    end
    b_r    <= b_nxt;
    pend_r <= pend_nxt;
  end

  mptr_ram #(.WIDTH(8), .DEPTH(PAT_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (in_byte_value),
    .re    (pat_re),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  mptr_ram #(.WIDTH(PAT_IW), .DEPTH(PAT_DEPTH)) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (fail_waddr),
    .wdata (fail_wdata),
    .re    (fail_re),
    .raddr (fail_raddr),
    .rdata (fail_rdata)
  );

  mptr_ram #(.WIDTH(REP_DW), .DEPTH(REP_DEPTH)) u_rep_ram (
    .clk   (clk),
    .we    (rep_we),
    .waddr ({nix, scnt_r[nix][REP_IW-1:0]}),
    .wdata ({in_response_tag, in_response_length}),
    .re    (rep_re),
    .raddr ({tix, rot_r[tix]}),
    .rdata (rep_rdata)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign status.idle   = (state_r == S_IDLE);
  assign status.pend_v = pend_v_r;

endmodule

[tb/multi_pattern_trigger_responder_tb.sv]
// ----------------------------------------------------------------------------
// multi_pattern_trigger_responder_tb: self-checking bench of the trigger table
// Loads trigger patterns and responses, streams data bytes through the
// block, predicts every match result and checks it against the output.
// ----------------------------------------------------------------------------

// Scoreboard: holds its own copy of the trigger table and the queue of
// results that the data bytes seen so far must produce.
class trigger_scoreboard;
  logic [7:0]  pat_mem [mptr_pkg::PAT_DEPTH];
  logic [4:0]  fail_mem [mptr_pkg::PAT_DEPTH];
  logic [15:0] tag_mem [mptr_pkg::REP_DEPTH];
  logic [15:0] len_mem [mptr_pkg::REP_DEPTH];
  int unsigned n_trig, loaded, prefix;
  int unsigned size_q [8];
  int unsigned pos_q [8];
  int unsigned rot_q [8];
  int unsigned cap_q [8];
  int unsigned cnt_q [8];
  logic [38:0] pending_results [$];
  int unsigned errors;
  int unsigned matched;

  function new();
    n_trig = 0; loaded = 0; prefix = 0; errors = 0; matched = 0;
    foreach (size_q[i]) begin
      size_q[i] = 0; pos_q[i] = 0; rot_q[i] = 0; cap_q[i] = 0; cnt_q[i] = 0;
    end
  endfunction

  function bit complete(int unsigned t);
    if (size_q[t] == 0) return 0;
    if (t + 1 == n_trig) return loaded >= size_q[t];
    return 1;
  endfunction

  // Notes one accepted input transaction and queues the results it causes.
  function void note_input(logic [1:0] kind, logic [7:0] b, logic [5:0] plen,
                           logic [3:0] pcap, logic [15:0] rtag, logic [15:0] rlen);
    int unsigned t, k, base, p, n, r, c, first;
    logic [38:0] res;
    case (kind)
      mptr_pkg::KIND_BEGIN: begin
        if (n_trig < 8) begin
          size_q[n_trig] = (plen > 32) ? 32 : plen;
          cap_q[n_trig] = (pcap > 8) ? 8 : pcap;
          cnt_q[n_trig] = 0; pos_q[n_trig] = 0; rot_q[n_trig] = 0;
          loaded = 0; prefix = 0; n_trig++;
        end
      end
      mptr_pkg::KIND_PATTERN: begin
        if (n_trig != 0 && loaded < size_q[n_trig-1]) begin
          base = (n_trig - 1) * 32;
          pat_mem[base + loaded] = b;
          if (loaded == 0) k = 0;
          else begin
            k = prefix;
            while (k > 0 && pat_mem[base + k] != b) k = fail_mem[base + k - 1];
            if (pat_mem[base + k] == b) k++;
          end
          fail_mem[base + loaded] = 5'(k);
          prefix = k; loaded++;
        end
      end
      mptr_pkg::KIND_REPLY: begin
        if (n_trig != 0 && cnt_q[n_trig-1] < cap_q[n_trig-1]) begin
          t = n_trig - 1;
          tag_mem[t*8 + cnt_q[t]] = rtag;
          len_mem[t*8 + cnt_q[t]] = rlen;
          cnt_q[t]++;
        end
      end
      default: begin
        n = 0;
        first = pending_results.size();
        for (t = 0; t < n_trig; t++) begin
          if (!complete(t)) continue;
          base = t * 32; p = pos_q[t];
          while (p > 0 && pat_mem[base + p] != b) p = fail_mem[base + p - 1];
          if (pat_mem[base + p] == b) p++;
          if (p >= size_q[t]) begin
            p = 0;
            if (cnt_q[t] > 0) begin
              r = rot_q[t] % cnt_q[t];
              c = t * 8 + r;
              res = {t[2:0], r[2:0], tag_mem[c], len_mem[c], 1'b0};
              pending_results.insert(pending_results.size(), res);
              rot_q[t] = (r + 1) % cnt_q[t];
              n++;
            end
          end
          pos_q[t] = p;
        end
        // The final result of the byte carries the last flag.
        if (n > 0) pending_results[first + n - 1][0] = 1'b1;
      end
    endcase
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0h, wanted %0h", what, got, want);
    errors++;
  endtask

  // Checks one accepted result transaction against the oldest expectation.
  task check_result(logic [2:0] trig, logic [2:0] slot, logic [15:0] tag,
                    logic [15:0] len, logic last);
    logic [38:0] w;
    if (pending_results.size() == 0) begin
      report("unexpected result, trigger", 16'(trig), 16'd0);
      return;
    end
    w = pending_results.pop_front();
    matched++;
    if (trig !== w[38:36]) report("trigger_index", 16'(trig), 16'(w[38:36]));
    if (slot !== w[35:33]) report("response_slot", 16'(slot), 16'(w[35:33]));
    if (tag !== w[32:17]) report("reply_tag", tag, w[32:17]);
    if (len !== w[16:1]) report("reply_length", len, w[16:1]);
    if (last !== w[0]) report("last", 16'(last), 16'(w[0]));
  endtask
endclass

module multi_pattern_trigger_responder_tb;
  import mptr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [7:0]  in_byte_value;
  logic [5:0]  in_pattern_length;
  logic [3:0]  in_response_capacity;
  logic [15:0] in_response_tag;
  logic [15:0] in_response_length;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_trigger_index;
  logic [2:0]  out_response_slot;
  logic [15:0] out_reply_tag;
  logic [15:0] out_reply_length;
  logic        out_last;

  multi_pattern_trigger_responder dut (.*);

  trigger_scoreboard board = new();

  // Idling control. The quiet window switches idling off on both sides;
  // the hold-off keeps the receiver stalled for a long stretch.
  bit          quiet_window;
  bit          hold_off;
  int unsigned cycle_count;
  int unsigned items_sent;
  // Alphabet used for patterns and data; kept small so that matches occur.
  logic [7:0]  alphabet [4];

  localparam int unsigned CYCLE_LIMIT = 600000;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Monitor: a result transaction is taken at a rising edge where valid and
  // ready are both high; input transactions are noted the same way.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_input(in_kind, in_byte_value, in_pattern_length,
                       in_response_capacity, in_response_tag, in_response_length);
    if (rst_n && out_valid && out_ready)
      board.check_result(out_trigger_index, out_response_slot, out_reply_tag,
                         out_reply_length, out_last);
  end

  // Receiver: ready changes on the falling edge, idling about 21 percent of the
  // time unless the quiet window or a hold-off is in force.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else if (quiet_window) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 21);
  end

  // Offers one transaction and holds it until the block accepts it. Valid
  // only drops when the sender idles, so items can follow back to back.
  task send_item(logic [1:0] kind, logic [7:0] b, logic [5:0] plen,
                 logic [3:0] pcap, logic [15:0] rtag, logic [15:0] rlen);
    while (!quiet_window && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_byte_value <= b;
    in_pattern_length <= plen;
    in_response_capacity <= pcap;
    in_response_tag <= rtag;
    in_response_length <= rlen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task send_begin(int unsigned plen, int unsigned pcap);
    send_item(KIND_BEGIN, 8'($urandom), 6'(plen), 4'(pcap), 16'($urandom),
              16'($urandom));
  endtask

  task send_pattern(logic [7:0] b);
    send_item(KIND_PATTERN, b, 6'($urandom), 4'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task send_reply(logic [15:0] rtag, logic [15:0] rlen);
    send_item(KIND_REPLY, 8'($urandom), 6'($urandom), 4'($urandom), rtag, rlen);
  endtask

  task send_data(logic [7:0] b);
    send_item(KIND_DATA, b, 6'($urandom), 4'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  function logic [7:0] pick_symbol();
    return alphabet[$urandom_range(3)];
  endfunction

  // Builds a full trigger: begin, every pattern byte, then a few responses.
  task load_trigger(int unsigned plen, int unsigned pcap, int unsigned nrep);
    send_begin(plen, pcap);
    for (int i = 0; i < plen && i < 32; i++) send_pattern(pick_symbol());
    for (int i = 0; i < nrep; i++) send_reply(16'($urandom), 16'($urandom));
  endtask

  initial begin
    in_valid = 1'b0;
    in_kind = KIND_DATA;
    in_byte_value = 8'd0;
    in_pattern_length = 6'd0;
    in_response_capacity = 4'd0;
    in_response_tag = 16'd0;
    in_response_length = 16'd0;
    rst_n = 1'b0;
    quiet_window = 1'b0;
    hold_off = 1'b0;
    items_sent = 0;
    alphabet[0] = 8'h00; alphabet[1] = 8'hFF;
    alphabet[2] = 8'h5A; alphabet[3] = 8'hA5;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Pattern bytes and responses before any trigger exist
    // must be ignored.
    send_pattern(8'hFF);
    send_reply(16'hFFFF, 16'hFFFF);
    send_data(8'hFF);
    // A zero-length pattern never matches, even with a response.
    send_begin(0, 1);
    send_reply(16'h1111, 16'h0000);
    send_data(8'h00);
    // Trigger 1: repeated symbol, which exercises the failure back-off, and
    // a zero response length. A surplus pattern byte follows.
    send_begin(2, 2);
    send_pattern(8'h00); send_pattern(8'h00); send_pattern(8'hFF);
    send_reply(16'hFFFF, 16'h0000);
    send_reply(16'h0000, 16'hFFFF);
    send_reply(16'h1234, 16'h5678);   // beyond the capacity, ignored
    // Trigger 2: oversized begin saturates to the longest pattern and the
    // largest capacity; it matches without responses and stays incomplete
    // until all bytes arrive, so data now only reaches trigger 1.
    send_begin(63, 15);
    send_data(8'h00); send_data(8'h00); send_data(8'h00);
    for (int i = 0; i < 32; i++) send_pattern(8'hFF);
    send_data(8'hFF);

    // Random part. Fill the table with well-formed triggers of short
    // patterns over the small alphabet, then stream data mostly from it.
    for (int t = 3; t < 9; t++)
      load_trigger($urandom_range(1, 4), $urandom_range(0, 9), $urandom_range(0, 9));
    // The table is full now: this begin is ignored, and so is its byte, as the newest pattern is complete.
    send_begin(5, 3);
    send_pattern(8'h00);

    // A quiet stretch with no idling on either side.
    quiet_window = 1'b1;
    for (int i = 0; i < 40; i++) send_data(pick_symbol());
    quiet_window = 1'b0;

    // Receiver hold-off while data keeps coming, so the block backs up.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_data(pick_symbol());
    join

    while (items_sent < 260) begin
      case ($urandom_range(9))
        0: send_item(2'($urandom), 8'($urandom), 6'($urandom), 4'($urandom),
                     16'($urandom), 16'($urandom));
        1: send_data(8'($urandom));
        default: send_data(pick_symbol());
      endcase
    end
    in_valid <= 1'b0;

    // Drain: wait for all expected results, then for the block to settle.
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Sent %0d input transactions over a full trigger table;", items_sent);
    $display("checked %0d match results, with %0d mismatches.",
             board.matched, board.errors);
    if (board.errors == 0 && board.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
